// ===== src/fqkd_pkg.sv =====
// Package for the key-delete FIFO: widths, operation and status codes,
// and the command struct broadcast to the cell row. No dependencies.
package fqkd_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_REM = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // Command seen by every cell in the cycle a request is accepted.
  typedef struct packed {
    logic enq;
    logic deq;
    logic rem;
    key_t key;
  } cell_cmd_t;

endpackage

// ===== src/fqkd_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on fqkd_pkg for field widths.
interface fqkd_req_if;
  logic                            valid;
  logic                            ready;
  logic [fqkd_pkg::OP_W-1:0]       op;
  logic signed [fqkd_pkg::KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface fqkd_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [fqkd_pkg::KEY_W-1:0] value;
  logic [fqkd_pkg::ST_W-1:0]         status;
  logic [fqkd_pkg::OCC_W-1:0]        occupancy;
  logic                              empty_res;

  modport source (output valid, output value, output status, output occupancy,
                  output empty_res, input ready);
  modport sink   (input valid, input value, input status, input occupancy,
                  input empty_res, output ready);
endinterface

// ===== src/fqkd_cell.sv =====
// One storage cell of the queue row: holds a key, compares it with the
// request key and takes its right neighbor's key to close a gap. Uses fqkd_pkg.
module fqkd_cell (
  input  logic                clk,
  input  fqkd_pkg::cell_cmd_t cmd,
  input  logic                tail,      // this cell is the first free slot
  input  logic                occ,       // this cell holds a live entry
  input  logic                seen_in,   // a match lies to the left
  input  fqkd_pkg::key_t      right_key,
  output logic                seen_out,
  output fqkd_pkg::key_t      key_q
);
  import fqkd_pkg::*;

  logic match;
  logic shift;

  assign match    = cmd.rem && occ && (key_q == cmd.key);
  assign seen_out = seen_in || match;
  // Dequeue shifts the whole row; remove shifts from the match onward.
  assign shift    = cmd.deq || (cmd.rem && seen_out);

  always_ff @(posedge clk) begin
    if (shift) begin
      key_q <= right_key;
    end else if (cmd.enq && tail) begin
      key_q <= cmd.key;
    end
  end

endmodule

// ===== src/fifo_queue_with_key_delete_unit.sv =====
// Top level of the key-delete FIFO: a row of fqkd_cell instances plus the
// occupancy counter and the result register. Uses fqkd_pkg and fqkd_if.
//
// req : valid/ready request channel with op and key. Enqueue puts key at the
//       tail, dequeue pops the head, remove deletes the first entry from the
//       head whose key equals key and closes the gap. Op code 3 reports ok.
// res : one result per request: the popped key (zero otherwise), a status
//       (ok, empty, not found, full), the occupancy after it and an empty flag.
// Timing: a request executes in the cycle it is accepted. Every cell compares
//   its key with the request key in parallel, a match flag ripples along the
//   row to find the first hit, and the cells at and behind the hit take their
//   right neighbor's key on the same edge. res shows the result in the next
//   cycle. One request per cycle unless res stalls, set by the single result
//   register: req.ready is high whenever it is empty or being taken.
// Reset: rst (synchronous, active high) empties the queue and drops any
//   pending result. Cell contents are not cleared; only live entries are read.
// Stall: while res is stalled with a result pending, req.ready is low and the
//   queue holds its state.
module fifo_queue_with_key_delete_unit (
  input  logic      clk,
  input  logic      rst,
  fqkd_req_if.sink  req,
  fqkd_res_if.source res
);
  import fqkd_pkg::*;

  cnt_t      count;
  cnt_t      count_next;
  logic      accept;
  logic      full;
  logic      nonempty;
  cell_cmd_t cmd;
  key_t      keys [DEPTH];
  logic      seen [DEPTH+1];
  logic      hit;
  status_t   status_next;
  key_t      value_next;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);

  // Accept a request whenever the result slot is free or draining.
  assign req.ready = !res.valid || res.ready;
  assign accept    = req.valid && req.ready;

  // Broadcast the command; gate failing operations so no cell moves.
  assign cmd.enq = accept && (req.op == OP_ENQ) && !full;
  assign cmd.deq = accept && (req.op == OP_DEQ) && nonempty;
  assign cmd.rem = accept && (req.op == OP_REM);
  assign cmd.key = req.key;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fqkd_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .tail      (CNT_W'(i) == count),
      .occ       (CNT_W'(i) < count),
      .seen_in   (seen[i]),
      .right_key ((i + 1 < DEPTH) ? keys[(i + 1) % DEPTH] : keys[i]),
      .seen_out  (seen[i+1]),
      .key_q     (keys[i])
    );
  end

  assign hit = seen[DEPTH];

  // Next count, status and popped value.
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    value_next  = '0;
    if (accept) begin
      case (req.op)
        OP_ENQ: begin
          if (full) status_next = ST_FULL;
          else      count_next  = count + CNT_W'(1);
        end
        OP_DEQ: begin
          if (!nonempty) begin
            status_next = ST_EMPTY;
          end else begin
            value_next = keys[0];
            count_next = count - CNT_W'(1);
          end
        end
        OP_REM: begin
          if (hit) count_next  = count - CNT_W'(1);
          else     status_next = ST_NOT_FOUND;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      res.value     <= value_next;
      res.status    <= status_next;
      res.occupancy <= OCC_W'(count_next);
      res.empty_res <= (count_next == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy exceeds depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.enq |=> count == $past(count) + CNT_W'(1))
    else $error("enqueue did not advance count");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> count == $past(count))
    else $error("queue changed while result stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.empty_res == (res.occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

endmodule
